[rtl/core/dbz_pa_pkg.sv]
// ----------------------------------------------------------------------------
// dbz_pa_pkg
// Shared constants, register indexes and the exp2 segment table for the
// dbz power accumulator.
// ----------------------------------------------------------------------------
package dbz_pa_pkg;

  // table and fixed-point sizes
  localparam int EXP_TABLE_BITS = 6;
  localparam int SUM_FRAC_BITS  = 16;
  localparam int TAB_N          = 1 << EXP_TABLE_BITS;
  localparam int TAB_IW         = EXP_TABLE_BITS + 1;
  localparam int FRAC_G         = 16 - EXP_TABLE_BITS;

  localparam int DBZ_W   = 16;
  localparam int EXP_W   = 16;
  localparam int SUM_W   = 63;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  // log2(10)/10 in Q20
  localparam logic [19:0] LOG2_10_DIV_10 = 20'd348329;

  // term shift: n + SUM_FRAC_BITS - 30, limits of the shifter
  localparam logic signed [12:0] SHIFT_BIAS = 13'(SUM_FRAC_BITS - 30);
  localparam logic signed [12:0] MAX_LSH    = 13'sd32;
  localparam logic signed [12:0] MAX_RSH    = 13'sd40;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_MIN_DBZ    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_DBZ    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MIN_ENABLE = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_ENABLE = 3'd3;
  localparam logic [CFG_AW-1:0] REG_INV_EXP    = 3'd4;

  // register reset values
  localparam logic signed [DBZ_W-1:0] MIN_DBZ_RST = 16'sd0;
  localparam logic signed [DBZ_W-1:0] MAX_DBZ_RST = 16'sd32767;
  localparam logic [EXP_W-1:0]        INV_EXP_RST = 16'd4096;

  typedef logic [31:0] exp_tab_t [0:TAB_N];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 values of 2^(i/TAB_N), built from repeated square roots of two
  function automatic exp_tab_t build_exp_table();
    logic [63:0] roots [0:EXP_TABLE_BITS];
    logic [63:0] e;
    exp_tab_t    t;
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= EXP_TABLE_BITS; j++) begin
      roots[j] = isqrt64(roots[j-1] << 30);
    end
    for (int i = 0; i < TAB_N; i++) begin
      e = 64'd1 << 30;
      for (int k = EXP_TABLE_BITS - 1; k >= 0; k--) begin
        if (((i >> k) & 1) != 0) begin
          e = (e * roots[EXP_TABLE_BITS - k] + (64'd1 << 29)) >> 30;
        end
      end
      t[i] = e[31:0];
    end
    t[TAB_N] = 32'h8000_0000;
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_table();

endpackage

[rtl/core/dbz_pa_in_if.sv]
// ----------------------------------------------------------------------------
// dbz_pa_in_if
// Sample request channel: one dBZ sample and its clear flag.
// ----------------------------------------------------------------------------
interface dbz_pa_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [dbz_pa_pkg::DBZ_W-1:0]      dbz;
  logic                                     clear_first;

  modport source (output valid, output dbz, output clear_first, input ready);
  modport sink   (input valid, input dbz, input clear_first, output ready);
endinterface

[rtl/core/dbz_pa_out_if.sv]
// ----------------------------------------------------------------------------
// dbz_pa_out_if
// Result channel: running sum and status of one processed sample.
// ----------------------------------------------------------------------------
interface dbz_pa_out_if;
  logic                              valid;
  logic                              ready;
  logic [dbz_pa_pkg::SUM_W-1:0]      running_sum;
  logic                              sample_taken;
  logic                              sum_saturated;

  modport source (output valid, output running_sum, output sample_taken,
                  output sum_saturated, input ready);
  modport sink   (input valid, input running_sum, input sample_taken,
                  input sum_saturated, output ready);
endinterface

[rtl/core/dbz_power_accumulator_top.sv]
// ----------------------------------------------------------------------------
// dbz_power_accumulator_top
// Power-law accumulation of dBZ samples: adds 10^(dbz*inv_exp/10) to a
// saturating Q47.16 sum held in a one-entry state memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : sample requests (dbz Q7.8, clear_first), valid/ready.
//   out_ch : one result per sample (running_sum, sample_taken,
//            sum_saturated), valid/ready.
//   cfg_*  : register writes, index 0..4 = min_dbz, max_dbz, min_enable,
//            max_enable, inv_exp; other indexes are ignored.
// Sequencing: the sequencer walks one sample through two multiplies,
//   table lookup, interpolation, shift and the read-modify-write of the
//   state memory before taking the next one; the result is registered
//   in the output register at the accumulate step.
// Reset: registers take their defaults, the state memory reads as zero
//   until first written, no result is pending.
// Stall: a finished result waits in the output register; the next sample
//   is still taken and runs up to the accumulate step, where it holds
//   until the output register frees.
// ----------------------------------------------------------------------------
module dbz_power_accumulator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  dbz_pa_in_if.sink                      in_ch,
  dbz_pa_out_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [dbz_pa_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [dbz_pa_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL1   = 3'd1;
  localparam logic [2:0] S_MUL2   = 3'd2;
  localparam logic [2:0] S_TAB    = 3'd3;
  localparam logic [2:0] S_INTERP = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_ACC    = 3'd6;

  localparam int T = dbz_pa_pkg::EXP_TABLE_BITS;
  localparam int G = dbz_pa_pkg::FRAC_G;
  localparam int W = dbz_pa_pkg::SUM_W;

  // configuration registers
  logic signed [15:0] min_dbz_r;
  logic signed [15:0] max_dbz_r;
  logic               min_en_r;
  logic               max_en_r;
  logic [15:0]        inv_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dbz_r <= dbz_pa_pkg::MIN_DBZ_RST;
      max_dbz_r <= dbz_pa_pkg::MAX_DBZ_RST;
      min_en_r  <= 1'b0;
      max_en_r  <= 1'b0;
      inv_exp_r <= dbz_pa_pkg::INV_EXP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dbz_pa_pkg::REG_MIN_DBZ:    min_dbz_r <= $signed(cfg_wdata);
        dbz_pa_pkg::REG_MAX_DBZ:    max_dbz_r <= $signed(cfg_wdata);
        dbz_pa_pkg::REG_MIN_ENABLE: min_en_r  <= cfg_wdata[0];
        dbz_pa_pkg::REG_MAX_ENABLE: max_en_r  <= cfg_wdata[0];
        dbz_pa_pkg::REG_INV_EXP:    inv_exp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  logic [2:0] state_r, state_nxt;
  logic       in_acc;
  logic       acc_go;
  logic       out_valid_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign acc_go      = (state_r == S_ACC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_TAB;
      S_TAB:    state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_SHIFT;
      S_SHIFT:  state_nxt = S_ACC;
      S_ACC:    if (acc_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // sample capture: threshold test on the raw sample, then clamp
  logic signed [15:0] d_r, d_nxt;
  logic               clear_r;
  logic               taken_r, taken_nxt;

  always_comb begin
    taken_nxt = !(min_en_r && (in_ch.dbz < min_dbz_r));
    d_nxt     = (max_en_r && (in_ch.dbz > max_dbz_r)) ? max_dbz_r : in_ch.dbz;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r     <= d_nxt;
      clear_r <= in_ch.clear_first;
      taken_r <= taken_nxt;
    end
  end

  // exponent: p = dbz * inv_exp * log2(10)/10 in two multiplies
  logic signed [32:0] prod1_r;
  logic signed [51:0] prod2_r;
  logic signed [32:0] mul1_a, mul1_b;
  logic signed [51:0] mul2_a, mul2_b;

  always_comb begin
    mul1_a = {{17{d_r[15]}}, d_r};
    mul1_b = {17'b0, inv_exp_r};
    mul2_a = {{19{prod1_r[32]}}, prod1_r};
    mul2_b = {32'b0, dbz_pa_pkg::LOG2_10_DIV_10};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL1) prod1_r <= mul1_a * mul1_b;
    if (state_r == S_MUL2) prod2_r <= mul2_a * mul2_b;
  end

  // table lookup: y = p >> 24, n = integer part, f = fraction
  logic signed [11:0]          n_r;
  logic [31:0]                 e0_r;
  logic [31:0]                 diff_r;
  logic [G-1:0]                frac_r;
  logic [15:0]                 f_w;
  logic [dbz_pa_pkg::TAB_IW-1:0] idx_lo, idx_hi;
  logic [31:0]                 e_lo, e_hi;

  always_comb begin
    f_w    = prod2_r[39:24];
    idx_lo = {1'b0, f_w[15 -: T]};
    idx_hi = idx_lo + dbz_pa_pkg::TAB_IW'(1);
    e_lo   = dbz_pa_pkg::EXP_TAB[idx_lo];
    e_hi   = dbz_pa_pkg::EXP_TAB[idx_hi];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TAB) begin
      n_r    <= prod2_r[51:40];
      e0_r   <= e_lo;
      diff_r <= e_hi - e_lo;
      frac_r <= f_w[G-1:0];
    end
  end

  // linear interpolation between segment ends
  logic [31:0]     m_r;
  logic [31+G:0]   interp_p;

  assign interp_p = {{G{1'b0}}, diff_r} * {32'b0, frac_r};

  always_ff @(posedge clk) begin
    if (state_r == S_INTERP) m_r <= e0_r + interp_p[31+G:G];
  end

  // scale mantissa by 2^s, clip above the sum range, round half up below
  logic [W-1:0]       term_r, term_nxt;
  logic               clip_r, clip_nxt;
  logic signed [12:0] shift_s, rsh;
  logic [63:0]        lsh_val, rnd_val;

  always_comb begin
    shift_s  = $signed({n_r[11], n_r}) + dbz_pa_pkg::SHIFT_BIAS;
    rsh      = -shift_s;
    lsh_val  = {32'b0, m_r} << shift_s[5:0];
    rnd_val  = ({32'b0, m_r} + (64'd1 << (rsh[5:0] - 6'd1))) >> rsh[5:0];
    term_nxt = '0;
    clip_nxt = 1'b0;
    if (!shift_s[12]) begin
      if (shift_s > dbz_pa_pkg::MAX_LSH || lsh_val[63]) begin
        term_nxt = dbz_pa_pkg::SUM_MAX;
        clip_nxt = 1'b1;
      end else begin
        term_nxt = lsh_val[W-1:0];
      end
    end else if (rsh <= dbz_pa_pkg::MAX_RSH) begin
      term_nxt = rnd_val[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SHIFT) begin
      term_r <= term_nxt;
      clip_r <= clip_nxt;
    end
  end

  // state memory: {saturated_flag, power_sum}, read at accept, written back
  logic [W:0] state_mem [0:0];
  logic [W:0] rd_data_r;
  logic       mem_valid_r;
  logic [W:0] wr_data;

  always_ff @(posedge clk) begin
    if (acc_go) state_mem[0] <= wr_data;
    if (in_acc) rd_data_r <= mem_valid_r ? state_mem[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      mem_valid_r <= 1'b0;
    else if (acc_go) mem_valid_r <= 1'b1;
  end

  // accumulate
  logic [W-1:0] base_sum, sum_nxt;
  logic         base_sat, sat_nxt;
  logic [W:0]   add_w;

  always_comb begin
    base_sum = clear_r ? '0 : rd_data_r[W-1:0];
    base_sat = clear_r ? 1'b0 : rd_data_r[W];
    add_w    = {1'b0, base_sum} + {1'b0, term_r};
    sum_nxt  = base_sum;
    sat_nxt  = base_sat;
    if (taken_r) begin
      if (add_w[W]) begin
        sum_nxt = dbz_pa_pkg::SUM_MAX;
        sat_nxt = 1'b1;
      end else begin
        sum_nxt = add_w[W-1:0];
        sat_nxt = base_sat | clip_r;
      end
    end
    wr_data = {sat_nxt, sum_nxt};
  end

  // output register
  logic [W-1:0] out_sum_r;
  logic         out_taken_r;
  logic         out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      out_sum_r   <= sum_nxt;
      out_taken_r <= taken_r;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.running_sum   = out_sum_r;
  assign out_ch.sample_taken  = out_taken_r;
  assign out_ch.sum_saturated = out_sat_r;

  // checks
  a_result_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ACC))
    else $error("result appeared without an accumulate step");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MUL1) && !in_ch.ready)
    else $error("accepted sample did not start the sequence");

  a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    acc_go && taken_r && add_w[W] |=> out_sat_r && (out_sum_r == dbz_pa_pkg::SUM_MAX))
    else $error("sum overflow not saturated");

endmodule

[tb/sv/tb_dbz_power_accumulator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dbz_power_accumulator_top
// Self-checking bench for the dBZ power-law accumulator. Sample requests are
// run through a bit-exact fixed-point exp2 predictor as they are accepted.
// Every result is then checked in order against that prediction. The run
// covers directed threshold and saturation cases, then random samples under
// a range of register settings and flow-control patterns.
// ----------------------------------------------------------------------------
module tb_dbz_power_accumulator_top;

  localparam int          CLK_HALF      = 5;
  localparam int          RAND_PHASES   = 15;
  localparam int          PHASE_SAMPLES = 116;
  localparam int          LONG_HOLD     = 300;
  localparam int          SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam longint      LOG2_TEN_Q20  = 348329;
  localparam logic [63:0] SUM_CEIL      = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [dbz_pa_pkg::DBZ_W-1:0] dbz;
    logic                                clear_first;
  } sample_req_t;

  typedef struct {
    logic [dbz_pa_pkg::SUM_W-1:0] running_sum;
    logic                         sample_taken;
    logic                         sum_saturated;
  } sum_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [dbz_pa_pkg::CFG_AW-1:0]   cfg_addr;
  logic [dbz_pa_pkg::CFG_DW-1:0]   cfg_wdata;

  dbz_pa_in_if  in_ch ();
  dbz_pa_out_if out_ch ();

  dbz_power_accumulator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // register shadow and accumulator state of the predictor
  logic signed [dbz_pa_pkg::DBZ_W-1:0] thr_min;
  logic signed [dbz_pa_pkg::DBZ_W-1:0] thr_max;
  logic                                thr_min_en;
  logic                                thr_max_en;
  logic [dbz_pa_pkg::EXP_W-1:0]        inv_exp_q;
  logic [dbz_pa_pkg::SUM_W-1:0]        acc_sum = '0;
  logic                                acc_sat = 1'b0;
  logic [63:0]                         exp_seg [0:dbz_pa_pkg::TAB_N];

  sample_req_t pending_samples [$];
  sum_result_t expected_sums [$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_requests;
  int          stalls_served = 0;
  int          hold_left = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  always #CLK_HALF clk = ~clk;

  // Q16 exp2 term of one (clamped) sample, clip set when it tops the sum range
  function automatic logic [63:0] power_term(
      input logic signed [dbz_pa_pkg::DBZ_W-1:0] d, output bit clip);
    longint      prod;
    longint      y;
    longint      n_int;
    int          s;
    int          seg;
    logic [15:0] f;
    logic [63:0] rem;
    logic [63:0] m;
    logic [63:0] v;
    prod = longint'(d) * longint'(inv_exp_q) * LOG2_TEN_Q20;
    y     = prod >>> 24;
    n_int = y >>> 16;
    f     = y[15:0];
    seg   = int'(f >> dbz_pa_pkg::FRAC_G);
    rem   = 64'(f & ((16'd1 << dbz_pa_pkg::FRAC_G) - 16'd1));
    m     = exp_seg[seg] +
            (((exp_seg[seg+1] - exp_seg[seg]) * rem) >> dbz_pa_pkg::FRAC_G);
    s     = int'(n_int) + dbz_pa_pkg::SUM_FRAC_BITS - 30;
    clip  = 1'b0;
    if (s >= 0) begin
      if (s > 32) begin
        clip = 1'b1;
        return SUM_CEIL;
      end
      v = m << s;
      if (v > SUM_CEIL) begin
        clip = 1'b1;
        return SUM_CEIL;
      end
      return v;
    end
    if (-s > 40) return 64'd0;
    // round half up on the way down
    return (m + (64'd1 << (-s - 1))) >> (-s);
  endfunction

  function automatic void accumulate_sample(input sample_req_t req);
    logic signed [dbz_pa_pkg::DBZ_W-1:0] d;
    logic [63:0]                         term;
    bit                                  clip;
    sum_result_t                         res;
    d = req.dbz;
    res.sample_taken = 1'b0;
    if (req.clear_first) begin
      acc_sum = '0;
      acc_sat = 1'b0;
    end
    // minimum test sees the unclamped sample
    if (!(thr_min_en && (d < thr_min))) begin
      if (thr_max_en && (d > thr_max)) d = thr_max;
      term = power_term(d, clip);
      if (clip) acc_sat = 1'b1;
      if (term > SUM_CEIL - {1'b0, acc_sum}) begin
        acc_sum = SUM_CEIL[dbz_pa_pkg::SUM_W-1:0];
        acc_sat = 1'b1;
      end else begin
        acc_sum = acc_sum + term[dbz_pa_pkg::SUM_W-1:0];
      end
      res.sample_taken = 1'b1;
    end
    res.running_sum   = acc_sum;
    res.sum_saturated = acc_sat;
    expected_sums.push_back(res);
  endfunction

  function automatic void queue_sample(input logic signed [dbz_pa_pkg::DBZ_W-1:0] d,
                                       input logic clr);
    sample_req_t req;
    req.dbz         = d;
    req.clear_first = clr;
    pending_samples.push_back(req);
  endfunction

  task automatic write_reg(input logic [dbz_pa_pkg::CFG_AW-1:0] idx,
                           input logic [dbz_pa_pkg::CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dbz_pa_pkg::REG_MIN_DBZ:    thr_min    = data;
      dbz_pa_pkg::REG_MAX_DBZ:    thr_max    = data;
      dbz_pa_pkg::REG_MIN_ENABLE: thr_min_en = data[0];
      dbz_pa_pkg::REG_MAX_ENABLE: thr_max_en = data[0];
      dbz_pa_pkg::REG_INV_EXP:    inv_exp_q  = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_sums.size() != 0 || in_ch.valid)
      @(posedge clk);
  endtask

  // sample request driver
  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.dbz         <= '0;
      in_ch.clear_first <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) accumulate_sample(pending_samples.pop_front());
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered request
      end else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.dbz         <= pending_samples[0].dbz;
        in_ch.clear_first <= pending_samples[0].clear_first;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver flow control
  always @(posedge clk) begin : sum_monitor
    sum_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: result expected none actual sum %0d taken %0b sat %0b", $time,
                   out_ch.running_sum, out_ch.sample_taken, out_ch.sum_saturated);
          mismatch_count++;
        end else begin
          want = expected_sums.pop_front();
          if (out_ch.running_sum !== want.running_sum) begin
            $display("%0t: running_sum expected %0d actual %0d", $time,
                     want.running_sum, out_ch.running_sum);
            mismatch_count++;
          end
          if (out_ch.sample_taken !== want.sample_taken) begin
            $display("%0t: sample_taken expected %0b actual %0b", $time,
                     want.sample_taken, out_ch.sample_taken);
            mismatch_count++;
          end
          if (out_ch.sum_saturated !== want.sum_saturated) begin
            $display("%0t: sum_saturated expected %0b actual %0b", $time,
                     want.sum_saturated, out_ch.sum_saturated);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stalls_served != stall_requests) begin
        stalls_served <= stalls_served + 1;
        hold_left     <= LONG_HOLD;
        out_ch.ready  <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : main_seq
    logic [63:0]                         roots [0:dbz_pa_pkg::EXP_TABLE_BITS];
    logic [63:0]                         e;
    logic [63:0]                         root;
    logic [63:0]                         trial;
    logic signed [dbz_pa_pkg::DBZ_W-1:0] mn;
    logic signed [dbz_pa_pkg::DBZ_W-1:0] mx;
    logic                                men;
    logic                                xen;
    logic [dbz_pa_pkg::EXP_W-1:0]        ie;
    int                                  lo;
    int                                  near;
    int                                  sel;
    logic signed [dbz_pa_pkg::DBZ_W-1:0] d;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_addr          = '0;
    cfg_wdata         = '0;
    send_idle_pct     = 18;
    recv_idle_pct     = 45;
    stall_requests    = 0;

    // Q30 segment table of 2^(i/TAB_N) from successive square roots of two
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= dbz_pa_pkg::EXP_TABLE_BITS; j++) begin
      root = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= (roots[j-1] << 30)) root = trial;
      end
      roots[j] = root;
    end
    for (int i = 0; i < dbz_pa_pkg::TAB_N; i++) begin
      e = 64'd1 << 30;
      for (int k = dbz_pa_pkg::EXP_TABLE_BITS - 1; k >= 0; k--) begin
        if (((i >> k) & 1) != 0)
          e = (e * roots[dbz_pa_pkg::EXP_TABLE_BITS - k] + (64'd1 << 29)) >> 30;
      end
      exp_seg[i] = e;
    end
    exp_seg[dbz_pa_pkg::TAB_N] = 64'd1 << 31;

    thr_min    = dbz_pa_pkg::MIN_DBZ_RST;
    thr_max    = dbz_pa_pkg::MAX_DBZ_RST;
    thr_min_en = 1'b0;
    thr_max_en = 1'b0;
    inv_exp_q  = dbz_pa_pkg::INV_EXP_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unit exponent, no thresholds
    queue_sample(16'sh0000, 1'b1);
    queue_sample(16'sh7FFF, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd1, 1'b0);
    queue_sample(16'sd2560, 1'b0);
    wait_drained();

    // zero exponent gives exactly one per sample
    write_reg(dbz_pa_pkg::REG_INV_EXP, 16'h0000);
    queue_sample(16'sh7FFF, 1'b1);
    queue_sample(16'sh8000, 1'b0);
    wait_drained();

    // term clip at the largest exponent, then a term that rounds to zero
    write_reg(dbz_pa_pkg::REG_INV_EXP, 16'hFFFF);
    queue_sample(16'sh7FFF, 1'b1);
    queue_sample(16'sh0000, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    queue_sample(16'sh8000, 1'b0);
    wait_drained();

    // terms near 2^62 each, so the sum itself runs over
    write_reg(dbz_pa_pkg::REG_INV_EXP, 16'd6144);
    queue_sample(16'sd23630, 1'b1);
    queue_sample(16'sd23630, 1'b0);
    queue_sample(16'sd23630, 1'b0);
    wait_drained();

    // clamp value below the minimum: minimum test on the raw sample
    write_reg(dbz_pa_pkg::REG_INV_EXP, 16'd4096);
    write_reg(dbz_pa_pkg::REG_MIN_DBZ, 16'd2560);
    write_reg(dbz_pa_pkg::REG_MAX_DBZ, 16'd1280);
    write_reg(dbz_pa_pkg::REG_MIN_ENABLE, 16'd1);
    write_reg(dbz_pa_pkg::REG_MAX_ENABLE, 16'd1);
    // unmapped indexes must leave everything alone
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h0000);
    queue_sample(16'sd2000, 1'b1);
    queue_sample(16'sd2559, 1'b0);
    queue_sample(16'sd2560, 1'b0);
    queue_sample(16'sd3000, 1'b0);
    queue_sample(16'sh8000, 1'b1);
    wait_drained();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase < 5) begin
        send_idle_pct = 18;
        recv_idle_pct = 45;
      end else if (phase < 10) begin
        send_idle_pct = 45;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase)
        0: begin
          mn = 16'sh8000; mx = 16'sh7FFF; men = 1'b1; xen = 1'b1; ie = 16'hFFFF;
        end
        1: begin
          mn = 16'sh7FFF; mx = 16'sh8000; men = 1'b1; xen = 1'b1; ie = 16'h0000;
        end
        default: begin
          if ($urandom_range(3) == 0) begin
            mn = 16'($urandom());
            mx = 16'($urandom());
          end else begin
            lo = int'($urandom_range(20480)) - 5120;
            mn = 16'(lo);
            mx = 16'(lo + int'($urandom_range(10240)));
          end
          men = 1'($urandom_range(1));
          xen = 1'($urandom_range(1));
          case ($urandom_range(3))
            0:       ie = 16'($urandom());
            1:       ie = dbz_pa_pkg::INV_EXP_RST;
            default: ie = 16'($urandom_range(6144, 2048));
          endcase
        end
      endcase
      write_reg(dbz_pa_pkg::REG_MIN_DBZ, mn);
      write_reg(dbz_pa_pkg::REG_MAX_DBZ, mx);
      write_reg(dbz_pa_pkg::REG_MIN_ENABLE, {15'd0, men});
      write_reg(dbz_pa_pkg::REG_MAX_ENABLE, {15'd0, xen});
      write_reg(dbz_pa_pkg::REG_INV_EXP, ie);
      if (phase == 4) write_reg(3'($urandom_range(7, 5)), 16'($urandom()));

      // receiver holds off long enough to back up the input
      if (phase == 2) stall_requests++;

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // sender pause until the block has fully drained
        if (phase == 7 && n == PHASE_SAMPLES / 2) wait_drained();
        sel = $urandom_range(9);
        case (sel)
          0: d = 16'($urandom());
          1: begin
            near = int'(thr_min) + int'($urandom_range(6)) - 3;
            d = 16'((near > 32767) ? 32767 : ((near < -32768) ? -32768 : near));
          end
          2: begin
            near = int'(thr_max) + int'($urandom_range(6)) - 3;
            d = 16'((near > 32767) ? 32767 : ((near < -32768) ? -32768 : near));
          end
          3: d = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          default: d = 16'(int'($urandom_range(25600)) - 5120);
        endcase
        queue_sample(d, $urandom_range(11) == 0);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
